/* hdl/rme_pkg.sv */
// Shared types, codes and compare helper for the running median extractor.
package rme_pkg;

   typedef enum logic [1:0] {
      STAT_INSERTED = 2'd0,
      STAT_MEDIAN   = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   // Heap select: the lower half is a max-heap, the upper half a min-heap.
   localparam logic HEAP_LOWER = 1'b0;
   localparam logic HEAP_UPPER = 1'b1;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   heap;
   } sift_cmd_type;

   // True when a belongs above b in the selected heap.
   function automatic logic goes_above(logic signed [31:0] a, logic signed [31:0] b,
                                       logic heap);
      goes_above = (heap == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction

endpackage

/* hdl/running_median_extractor_core.sv */
// Top level of the running median extractor: sequencer, counters and result register.
//
// Keeps up to CAPACITY signed 32-bit values as a lower max-heap and an upper
// min-heap held in one memory with a registered read port and a write port. An
// insert (req_type 0) goes to the upper half when the store is empty or the
// value is not below the upper minimum, else to the lower half, and one value
// then moves between halves if they are out of balance. An extract (req_type 1)
// removes and returns the upper minimum, the value at rank floor(n/2)+1, then
// rebalances. Full inserts and empty extracts answer at once with status 3 or 2.
// Every item gives one result item with the count stored after it. The sift
// unit walks the heaps one memory read per cycle (two per level when sifting
// down). The block takes one item at a time; req_ready is high only when the
// sequencer is idle, and a waiting result does not hold off the next item.
// The heap memory needs no clearing after reset.
module running_median_extractor_core #(
   parameter int CAPACITY = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [31:0]                req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [31:0]                rsp_median,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_count
);

   // heap depth covers the one-value overshoot before a rebalance
   localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
   localparam int AW         = $clog2(HEAP_DEPTH);
   localparam int HCW        = $clog2(HEAP_DEPTH + 1);
   localparam int CW         = $clog2(CAPACITY + 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PEEK   = 8'b0000_0010,
      ST_INS    = 8'b0000_0100,
      ST_EXT    = 8'b0000_1000,
      ST_MVPOP  = 8'b0001_0000,
      ST_MVPUSH = 8'b0010_0000,
      ST_DONE   = 8'b0100_0000,
      ST_SPARE  = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [HCW-1:0]        lower_cnt_ff, lower_cnt_in;
   logic [HCW-1:0]        upper_cnt_ff, upper_cnt_in;
   logic                  mv_src_ff, mv_src_in;
   logic signed [31:0]    value_ff, value_in;
   rme_pkg::status_type   res_status_ff, res_status_in;
   logic signed [31:0]    res_median_ff, res_median_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic signed [31:0]    rsp_median_ff, rsp_median_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;

   logic                  do_push, do_pop, do_peek, sel_heap;
   logic signed [31:0]    push_val;
   rme_pkg::sift_cmd_type cmd;
   logic [AW-1:0]         cmd_n;
   logic [HCW-1:0]        sel_cnt;
   logic                  sift_done;
   logic signed [31:0]    sift_top;

   logic [HCW:0]          total;
   logic                  full, need_ul, need_lu, rsp_free;

   assign total    = (HCW+1)'(lower_cnt_ff) + (HCW+1)'(upper_cnt_ff);
   assign full     = (total >= (HCW+1)'(CAPACITY));
   assign need_ul  = ((HCW+1)'(upper_cnt_ff) > (HCW+1)'(lower_cnt_ff) + (HCW+1)'(1));
   assign need_lu  = (lower_cnt_ff > upper_cnt_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      mv_src_in     = mv_src_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_median_in = res_median_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      do_push       = 1'b0;
      do_pop        = 1'b0;
      do_peek       = 1'b0;
      sel_heap      = rme_pkg::HEAP_UPPER;
      push_val      = value_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               value_in      = req_value;
               push_val      = req_value;
               res_median_in = '0;
               if (req_type == rme_pkg::REQ_INSERT) begin
                  if (full) begin
                     res_status_in = rme_pkg::STAT_FULL;
                     state_in      = ST_DONE;
                  end else if (upper_cnt_ff == '0) begin
                     res_status_in = rme_pkg::STAT_INSERTED;
                     do_push       = 1'b1;
                     state_in      = ST_INS;
                  end else begin
                     // fetch the upper minimum to choose the half
                     res_status_in = rme_pkg::STAT_INSERTED;
                     do_peek       = 1'b1;
                     state_in      = ST_PEEK;
                  end
               end else begin
                  if (upper_cnt_ff == '0) begin
                     res_status_in = rme_pkg::STAT_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     res_status_in = rme_pkg::STAT_MEDIAN;
                     do_pop        = 1'b1;
                     state_in      = ST_EXT;
                  end
               end
            end
         end
         ST_PEEK: begin
            if (sift_done) begin
               do_push  = 1'b1;
               sel_heap = (value_ff < sift_top) ? rme_pkg::HEAP_LOWER : rme_pkg::HEAP_UPPER;
               state_in = ST_INS;
            end
         end
         ST_INS, ST_EXT: begin
            if (sift_done) begin
               if (state_ff == ST_EXT) begin
                  res_median_in = sift_top;
               end
               // at most one value has to cross to restore the balance
               if (need_ul) begin
                  do_pop    = 1'b1;
                  sel_heap  = rme_pkg::HEAP_UPPER;
                  mv_src_in = rme_pkg::HEAP_UPPER;
                  state_in  = ST_MVPOP;
               end else if (need_lu) begin
                  do_pop    = 1'b1;
                  sel_heap  = rme_pkg::HEAP_LOWER;
                  mv_src_in = rme_pkg::HEAP_LOWER;
                  state_in  = ST_MVPOP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MVPOP: begin
            if (sift_done) begin
               do_push  = 1'b1;
               sel_heap = !mv_src_ff;
               push_val = sift_top;
               state_in = ST_MVPUSH;
            end
         end
         ST_MVPUSH: begin
            if (sift_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the item over once the result register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_median_in = res_median_ff;
               rsp_count_in  = CW'(total);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // build the sift command and advance the counts as it issues
   assign sel_cnt = (sel_heap == rme_pkg::HEAP_LOWER) ? lower_cnt_ff : upper_cnt_ff;

   always_comb begin
      cmd.valid = do_push || do_pop || do_peek;
      cmd.heap  = sel_heap;
      cmd.op    = do_push ? rme_pkg::OP_PUSH : (do_pop ? rme_pkg::OP_POP : rme_pkg::OP_PEEK);
      cmd_n     = do_pop ? AW'(sel_cnt - HCW'(1)) : AW'(sel_cnt);
      lower_cnt_in = lower_cnt_ff;
      upper_cnt_in = upper_cnt_ff;
      if (sel_heap == rme_pkg::HEAP_LOWER) begin
         if (do_push) begin
            lower_cnt_in = lower_cnt_ff + HCW'(1);
         end else if (do_pop) begin
            lower_cnt_in = lower_cnt_ff - HCW'(1);
         end
      end else begin
         if (do_push) begin
            upper_cnt_in = upper_cnt_ff + HCW'(1);
         end else if (do_pop) begin
            upper_cnt_in = upper_cnt_ff - HCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_cnt_ff <= '0;
         upper_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lower_cnt_ff <= lower_cnt_in;
         upper_cnt_ff <= upper_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_src_ff     <= mv_src_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_median_ff <= res_median_in;
      rsp_status_ff <= rsp_status_in;
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
   end

   rme_sift_unit #(
      .AW (AW)
   ) u_sift (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_n     (cmd_n),
      .cmd_value (push_val),
      .done      (sift_done),
      .top       (sift_top)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

/* hdl/rme_sift_unit.sv */
// Shared sift unit: push, pop and peek on either heap, with the heap memory.
module rme_sift_unit #(
   parameter int AW = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rme_pkg::sift_cmd_type    cmd,
   input  logic [AW-1:0]            cmd_n,
   input  logic signed [31:0]       cmd_value,
   output logic                     done,
   output logic signed [31:0]       top
);

   typedef enum logic [7:0] {
      E_IDLE  = 8'b0000_0001,
      E_PUSH  = 8'b0000_0010,
      E_RD0   = 8'b0000_0100,
      E_RDN   = 8'b0000_1000,
      E_LEFT  = 8'b0001_0000,
      E_RIGHT = 8'b0010_0000,
      E_FIN   = 8'b0100_0000,
      E_SPARE = 8'b1000_0000
   } estate_type;

   logic signed [31:0] mem [2**(AW+1)];

   estate_type         state_ff, state_in;
   logic               heap_ff, heap_in;
   logic               peek_ff, peek_in;
   logic [AW-1:0]      n_ff, n_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      p_ff, p_in;
   logic signed [31:0] v_ff, v_in;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] lval_ff, lval_in;
   logic               lup_ff, lup_in;
   logic               done_ff, done_in;
   logic signed [31:0] rdata_ff;

   logic               rd_heap;
   logic [AW-1:0]      rd_idx;
   logic               wr_en;
   logic [AW-1:0]      wr_idx;
   logic signed [31:0] wr_data;

   logic [AW+1:0]      l_w, r_w, n_w, nl_w;
   logic [AW-1:0]      par_w, par_p_w;
   logic signed [31:0] cand;
   logic               lup_now, rup_now;

   assign l_w     = (AW+2)'({i_ff, 1'b1});
   assign r_w     = l_w + (AW+2)'(1);
   assign n_w     = (AW+2)'(n_ff);
   assign par_w   = (cmd_n - AW'(1)) >> 1;
   assign par_p_w = (p_ff - AW'(1)) >> 1;
   assign cand    = lup_ff ? lval_ff : v_ff;
   assign lup_now = rme_pkg::goes_above(rdata_ff, v_ff, heap_ff);
   assign rup_now = rme_pkg::goes_above(rdata_ff, cand, heap_ff);

   always_comb begin
      state_in = state_ff;
      heap_in  = heap_ff;
      peek_in  = peek_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      p_in     = p_ff;
      v_in     = v_ff;
      top_in   = top_ff;
      lval_in  = lval_ff;
      lup_in   = lup_ff;
      done_in  = 1'b0;
      rd_heap  = heap_ff;
      rd_idx   = '0;
      wr_en    = 1'b0;
      wr_idx   = i_ff;
      wr_data  = v_ff;
      nl_w     = '0;
      unique case (state_ff)
         E_IDLE: begin
            rd_heap = cmd.heap;
            if (cmd.valid) begin
               heap_in = cmd.heap;
               peek_in = (cmd.op == rme_pkg::OP_PEEK);
               n_in    = cmd_n;
               i_in    = cmd_n;
               v_in    = cmd_value;
               if (cmd.op == rme_pkg::OP_PUSH) begin
                  if (cmd_n == '0) begin
                     state_in = E_FIN;
                  end else begin
                     rd_idx   = par_w;
                     p_in     = par_w;
                     state_in = E_PUSH;
                  end
               end else begin
                  state_in = E_RD0;
               end
            end
         end
         E_PUSH: begin
            // move the parent down into the hole while the new value beats it
            if (rme_pkg::goes_above(v_ff, rdata_ff, heap_ff)) begin
               wr_en   = 1'b1;
               wr_data = rdata_ff;
               i_in    = p_ff;
               if (p_ff == '0) begin
                  state_in = E_FIN;
               end else begin
                  rd_idx = par_p_w;
                  p_in   = par_p_w;
               end
            end else begin
               state_in = E_FIN;
            end
         end
         E_RD0: begin
            top_in = rdata_ff;
            if (peek_ff) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               rd_idx   = n_ff;
               state_in = E_RDN;
            end
         end
         E_RDN: begin
            v_in = rdata_ff;
            i_in = '0;
            if (n_ff == '0) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else if (n_ff > AW'(1)) begin
               rd_idx   = AW'(1);
               state_in = E_LEFT;
            end else begin
               state_in = E_FIN;
            end
         end
         E_LEFT: begin
            lval_in = rdata_ff;
            lup_in  = lup_now;
            if (r_w < n_w) begin
               rd_idx   = r_w[AW-1:0];
               state_in = E_RIGHT;
            end else begin
               if (lup_now) begin
                  wr_en   = 1'b1;
                  wr_data = rdata_ff;
                  i_in    = l_w[AW-1:0];
               end
               state_in = E_FIN;
            end
         end
         E_RIGHT: begin
            if (rup_now || lup_ff) begin
               wr_en = 1'b1;
               if (rup_now) begin
                  wr_data = rdata_ff;
                  i_in    = r_w[AW-1:0];
               end else begin
                  wr_data = lval_ff;
                  i_in    = l_w[AW-1:0];
               end
               nl_w = (AW+2)'({i_in, 1'b1});
               if (nl_w < n_w) begin
                  rd_idx   = nl_w[AW-1:0];
                  state_in = E_LEFT;
               end else begin
                  state_in = E_FIN;
               end
            end else begin
               state_in = E_FIN;
            end
         end
         E_FIN: begin
            wr_en    = 1'b1;
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      heap_ff  <= heap_in;
      peek_ff  <= peek_in;
      n_ff     <= n_in;
      i_ff     <= i_in;
      p_ff     <= p_in;
      v_ff     <= v_in;
      top_ff   <= top_in;
      lval_ff  <= lval_in;
      lup_ff   <= lup_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{heap_ff, wr_idx}] <= wr_data;
      end
      rdata_ff <= mem[{rd_heap, rd_idx}];
   end

   assign done = done_ff;
   assign top  = top_ff;

endmodule

/* hdl/rme_checker.sv */
// Port-level checks for the running median extractor, bound to the top level.
module rme_port_checks #(
   parameter int CAPACITY = 1024
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic signed [31:0]            rsp_median,
   input logic [$clog2(CAPACITY+1)-1:0] rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median) && $stable(rsp_count))
      else $error("result item changed while stalled");

   a_median_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rme_pkg::STAT_MEDIAN) |-> (rsp_median == '0))
      else $error("median not zero without a returned median");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rme_pkg::STAT_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with values stored");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rme_pkg::STAT_FULL) |-> (rsp_count == CW'(CAPACITY)))
      else $error("full status below capacity");

endmodule

bind running_median_extractor_core rme_port_checks #(
   .CAPACITY (CAPACITY)
) u_rme_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_median (rsp_median),
   .rsp_count  (rsp_count)
);
